FILE: design/pwmcp_pkg.sv
// Shared types, constants and character codes for the PWM level command parser.
package pwmcp_pkg;

    localparam int CHANNELS = 6;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [7:0] CHR_HELP  = 8'h3f;
    localparam logic [7:0] CHR_QUERY = 8'h71;
    localparam logic [7:0] CHR_VALUE = 8'h76;
    localparam logic [7:0] CHR_CHAN  = 8'h6b;
    localparam logic [7:0] CHR_DOWN  = 8'h3c;
    localparam logic [7:0] CHR_UP    = 8'h3e;
    localparam logic [7:0] CHR_MINUS = 8'h2d;
    localparam logic [7:0] CHR_PLUS  = 8'h2b;
    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_9     = 8'h39;
    localparam logic [7:0] CHR_LA    = 8'h61;
    localparam logic [7:0] CHR_LF    = 8'h66;
    localparam logic [7:0] CHR_UA    = 8'h41;
    localparam logic [7:0] CHR_UF    = 8'h46;

    localparam logic [7:0] LEVEL_MAX = 8'hff;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_CH,
        MODE_V1,
        MODE_V2
    } mode_t;

    typedef enum logic [3:0] {
        ST_VAL_SET,
        ST_CH_SET,
        ST_QUERY,
        ST_HELP,
        ST_CH_LOW,
        ST_CH_HIGH,
        ST_VAL_LOW,
        ST_VAL_HIGH,
        ST_BAD_CMD,
        ST_BAD_HEX,
        ST_CH_RANGE
    } status_t;

    typedef struct packed {
        mode_t          mode;
        logic [CH_W-1:0] sel;
        logic [7:0]     partial;
        logic           has_result;
        status_t        status;
        logic           wr_en;
        logic [7:0]     wr_data;
        logic [7:0]     level;
    } dec_t;

endpackage

FILE: design/pwm_level_command_parser.sv
// PWM level command parser top level: input register, parse state, level store, result register.
// Takes one received character per cycle with no gaps while cmd_stall is low: the character is held in an
// input register, decoded against the parse state and the six-entry level store in one pass, and
// its result (if any) is registered in the result register when the character advances.
// The parse state and level store update on that same advance, so each character sees
// the effect of the one before it. A pending result whose transfer out is stalled holds the
// pipeline, also for characters that give no result ('k', 'v', first value digit).
module pwm_level_command_parser
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [7:0] rx_char,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [3:0] status,
    output logic [2:0] channel,
    output logic [7:0] level,
    output logic       level_write
);
    import pwmcp_pkg::*;

    logic            in_valid_reg;
    logic [7:0]      rx_char_reg;
    mode_t           mode_reg;
    logic [CH_W-1:0] sel_reg;
    logic [7:0]      partial_reg;
    logic [7:0]      levels_reg [CHANNELS];
    logic            rsp_valid_reg;
    status_t         status_reg;
    logic [2:0]      channel_reg;
    logic [7:0]      level_reg;
    logic            level_write_reg;

    logic [CH_W-1:0] rd_sel;
    logic [7:0]      rd_level;
    logic [7:0]      sel_wide;
    dec_t            dec;
    logic            advance;

    assign rd_level  = levels_reg[rd_sel];
    assign advance   = in_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall = in_valid_reg && !advance;
    assign sel_wide  = 8'(dec.sel);

    pwmcp_decode u_decode
    (
        .rx_char  (rx_char_reg),
        .mode     (mode_reg),
        .sel      (sel_reg),
        .partial  (partial_reg),
        .rd_sel   (rd_sel),
        .rd_level (rd_level),
        .dec      (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd_stall && cmd_valid)
        begin
            rx_char_reg <= rx_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            sel_reg     <= '0;
            partial_reg <= 8'h00;
            for (int i = 0; i < CHANNELS; i++)
            begin
                levels_reg[i] <= 8'h00;
            end
        end
        else if (advance)
        begin
            mode_reg    <= dec.mode;
            sel_reg     <= dec.sel;
            partial_reg <= dec.partial;
            if (dec.wr_en)
            begin
                levels_reg[dec.sel] <= dec.wr_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= dec.has_result;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && dec.has_result)
        begin
            status_reg      <= dec.status;
            channel_reg     <= sel_wide[2:0];
            level_reg       <= dec.level;
            level_write_reg <= dec.wr_en;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign channel     = channel_reg;
    assign level       = level_reg;
    assign level_write = level_write_reg;

    // hold: a write result always reports a set value
    a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && level_write_reg |-> status_reg == ST_VAL_SET)
        else $error("write strobe with non-set status");

    // hold: selected channel stays inside the store
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sel_reg) < CHANNELS)
        else $error("selected channel out of range");

    // hold: a stall on the input only while an item waits in the input register and the pending result is stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> in_valid_reg && rsp_valid_reg && rsp_stall)
        else $error("input stalled without a blocked result");

    // advance: a write lands in the store at the reported channel
    a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance && dec.wr_en |=> levels_reg[sel_reg] == $past(dec.wr_data))
        else $error("level write lost");

endmodule

FILE: design/pwmcp_decode.sv
// Single-pass command decode: next parse state, level update and result fields.
module pwmcp_decode
(
    input  logic [7:0]                  rx_char,
    input  pwmcp_pkg::mode_t            mode,
    input  logic [pwmcp_pkg::CH_W-1:0]  sel,
    input  logic [7:0]                  partial,
    output logic [pwmcp_pkg::CH_W-1:0]  rd_sel,
    input  logic [7:0]                  rd_level,
    output pwmcp_pkg::dec_t             dec
);
    import pwmcp_pkg::*;

    logic       hex_ok;
    logic [3:0] nib;
    logic [7:0] nib_off;

    always_comb
    begin
        hex_ok  = 1'b1;
        nib_off = 8'h00;
        if (rx_char >= CHR_0 && rx_char <= CHR_9)
        begin
            nib_off = rx_char - CHR_0;
        end
        else if (rx_char >= CHR_LA && rx_char <= CHR_LF)
        begin
            nib_off = rx_char - CHR_LA + 8'd10;
        end
        else if (rx_char >= CHR_UA && rx_char <= CHR_UF)
        begin
            nib_off = rx_char - CHR_UA + 8'd10;
        end
        else
        begin
            hex_ok = 1'b0;
        end
        nib = nib_off[3:0];
    end

    // next channel; the level store is read there
    always_comb
    begin
        rd_sel = sel;
        if (mode == MODE_CH)
        begin
            if (hex_ok && 32'(nib) < CHANNELS)
            begin
                rd_sel = CH_W'(nib);
            end
        end
        else if (mode == MODE_IDLE)
        begin
            if (rx_char == CHR_DOWN && sel != '0)
            begin
                rd_sel = sel - CH_W'(1);
            end
            else if (rx_char == CHR_UP && sel != CH_W'(CHANNELS - 1))
            begin
                rd_sel = sel + CH_W'(1);
            end
        end
    end

    always_comb
    begin
        dec.mode       = mode;
        dec.sel        = rd_sel;
        dec.partial    = partial;
        dec.has_result = 1'b1;
        dec.status     = ST_VAL_SET;
        dec.wr_en      = 1'b0;
        dec.wr_data    = rd_level;
        unique case (mode)
            MODE_CH:
            begin
                dec.mode = MODE_IDLE;
                if (!hex_ok)
                begin
                    dec.status = ST_BAD_HEX;
                end
                else if (32'(nib) < CHANNELS)
                begin
                    dec.status = ST_CH_SET;
                end
                else
                begin
                    dec.status = ST_CH_RANGE;
                end
            end
            MODE_V1:
            begin
                if (!hex_ok)
                begin
                    dec.mode   = MODE_IDLE;
                    dec.status = ST_BAD_HEX;
                end
                else
                begin
                    dec.mode       = MODE_V2;
                    dec.partial    = {nib, 4'h0};
                    dec.has_result = 1'b0;
                end
            end
            MODE_V2:
            begin
                dec.mode = MODE_IDLE;
                if (!hex_ok)
                begin
                    dec.status = ST_BAD_HEX;
                end
                else
                begin
                    dec.partial = partial | {4'h0, nib};
                    dec.wr_en   = 1'b1;
                    dec.wr_data = partial | {4'h0, nib};
                end
            end
            MODE_IDLE:
            begin
                priority if (rx_char == CHR_HELP)
                begin
                    dec.status = ST_HELP;
                end
                else if (rx_char == CHR_QUERY)
                begin
                    dec.status = ST_QUERY;
                end
                else if (rx_char == CHR_VALUE)
                begin
                    dec.partial    = 8'h00;
                    dec.mode       = MODE_V1;
                    dec.has_result = 1'b0;
                end
                else if (rx_char == CHR_CHAN)
                begin
                    dec.partial    = 8'h00;
                    dec.mode       = MODE_CH;
                    dec.has_result = 1'b0;
                end
                else if (rx_char == CHR_DOWN)
                begin
                    if (sel == '0)
                    begin
                        dec.status = ST_CH_LOW;
                    end
                    else
                    begin
                        dec.wr_en = 1'b1;
                    end
                end
                else if (rx_char == CHR_UP)
                begin
                    if (sel == CH_W'(CHANNELS - 1))
                    begin
                        dec.status = ST_CH_HIGH;
                    end
                    else
                    begin
                        dec.wr_en = 1'b1;
                    end
                end
                else if (rx_char == CHR_MINUS)
                begin
                    if (rd_level == 8'h00)
                    begin
                        dec.status = ST_VAL_LOW;
                    end
                    else
                    begin
                        dec.wr_en   = 1'b1;
                        dec.wr_data = rd_level - 8'd1;
                    end
                end
                else if (rx_char == CHR_PLUS)
                begin
                    if (rd_level == LEVEL_MAX)
                    begin
                        dec.status = ST_VAL_HIGH;
                    end
                    else
                    begin
                        dec.wr_en   = 1'b1;
                        dec.wr_data = rd_level + 8'd1;
                    end
                end
                else if (hex_ok)
                begin
                    dec.wr_en   = 1'b1;
                    dec.wr_data = {nib, nib};
                end
                else
                begin
                    dec.status = ST_BAD_CMD;
                end
            end
            default:
            begin
                dec.mode = MODE_IDLE;
            end
        endcase
        dec.level = dec.wr_en ? dec.wr_data : rd_level;
    end

endmodule
